### rtl/n2ew_pkg.sv
// Package for the number to English word token block.
// Holds the word codes, divide constants and token list types.
// No dependencies.
`timescale 1ns / 1ps

package n2ew_pkg;

	// Width of one word token and the longest token list for one value.
	localparam int unsigned WordW     = 5;
	localparam int unsigned MaxTokens = 6;
	localparam int unsigned CountW    = 3;

	// Word codes.
	localparam logic [WordW-1:0] WORD_EMPTY    = 5'd0;
	localparam logic [WordW-1:0] WORD_TEN      = 5'd10;
	localparam logic [WordW-1:0] WORD_TWENTY   = 5'd20;
	localparam logic [WordW-1:0] WORD_HUNDRED  = 5'd28;
	localparam logic [WordW-1:0] WORD_THOUSAND = 5'd29;

	// Range of values that are spelled out.
	localparam logic [15:0] VALUE_MIN = 16'd1;
	localparam logic [15:0] VALUE_MAX = 16'd3000;

	// Thousands boundaries on the low twelve bits of an in-range value.
	localparam logic [11:0] K1 = 12'd1000;
	localparam logic [11:0] K2 = 12'd2000;
	localparam logic [11:0] K3 = 12'd3000;

	// Reciprocals: x / 100 = (x * 5243) >> 19 for x < 1000,
	// x / 10 = (x * 205) >> 11 for x < 100.
	localparam logic [22:0] RECIP100 = 23'd5243;
	localparam int unsigned SHIFT100 = 19;
	localparam logic [14:0] RECIP10  = 15'd205;
	localparam int unsigned SHIFT10  = 11;

	typedef logic [WordW-1:0] word_t;
	typedef logic [CountW-1:0] count_t;
	typedef word_t [MaxTokens-1:0] token_list_t;

endpackage

### rtl/number_to_english_word_tokens.sv
// Top level of the number to English word token block.
// A five-stage digit pipeline feeds a token emitter; depends on n2ew_pkg.
// Usage:
//   Input: drive value and raise start; the value transfers at a rising edge
//   where start is high and busy is low. Values may transfer on consecutive
//   cycles as long as busy stays low.
//   Output: each word token appears on word_code for exactly one cycle with
//   strobe high; last_word marks the final token of a value. The receiver
//   cannot hold results off, so tokens leave one per cycle without gaps.
//   Path: a value moves at its transfer edge into stage one, then through stages
//   two to five and into the emitter's output register; a busy emitter can hold
//   it in the pipeline on the way.
//   Throughput: the emitter sends one token per cycle, so a value occupies it
//   for one slot per token: a single token for an out-of-range value and
//   one to six for a value from 1 to 3000. While the emitter is busy the
//   pipeline fills and then raises busy; nothing is dropped or repeated.
//   Reset: arst_n low clears all valid bits and the strobe; no result is
//   in flight afterward and busy is low.
//   A value of 0 or above 3000 gives one empty token with last_word set.
`timescale 1ns / 1ps

module number_to_english_word_tokens (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [15:0]         value,
	output n2ew_pkg::word_t     word_code,
	output logic                last_word,
	output logic                strobe
);
	import n2ew_pkg::*;

	// Stage valid bits and ready chain.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic act_q;

	// Stage payloads.
	logic        rng_s1, rng_s2, rng_s3, rng_s4;
	logic [1:0]  d1000_s1, d1000_s2, d1000_s3, d1000_s4;
	logic [9:0]  r1000_s1, r1000_s2;
	logic [3:0]  d100_s2, d100_s3, d100_s4;
	logic [6:0]  r100_s3, r100_s4;
	logic [3:0]  d10_s4;
	token_list_t tok_s5;
	count_t      cnt_s5;

	// Emitter state.
	token_list_t tok_q;
	count_t      cnt_q;
	count_t      idx_q;
	word_t       word_code_q;
	logic        last_word_q;
	logic        strobe_q;

	logic accept;
	logic take;

	// Each stage moves when the next one is free; the emitter takes a new list when idle.
	assign take   = !act_q;
	assign rdy_s5 = !v_s5 || take;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign busy   = !rdy_s1;
	assign accept = start && !busy;

	// Stage 1 logic: range check and thousands digit by comparison.
	logic [11:0] v12;
	logic [11:0] sub1000;
	logic [1:0]  d1000_c;
	always_comb begin
		v12 = value[11:0];
		if (v12 >= K3) begin
			d1000_c = 2'd3;
			sub1000 = K3;
		end else if (v12 >= K2) begin
			d1000_c = 2'd2;
			sub1000 = K2;
		end else if (v12 >= K1) begin
			d1000_c = 2'd1;
			sub1000 = K1;
		end else begin
			d1000_c = 2'd0;
			sub1000 = 12'd0;
		end
	end

	// Stage 2 logic: hundreds digit by reciprocal multiplication.
	logic [22:0] prod100;
	assign prod100 = {13'd0, r1000_s1} * RECIP100;

	// Stage 3 logic: remainder below one hundred.
	logic [9:0] r100_full;
	assign r100_full = r1000_s2 - ({6'd0, d100_s2} * 10'd100);

	// Stage 4 logic: tens digit by reciprocal multiplication.
	logic [14:0] prod10;
	assign prod10 = {8'd0, r100_s3} * RECIP10;

	// Stage 5 logic: ones digit and the ordered token list.
	logic [6:0]  d1_full;
	logic [3:0]  d1;
	token_list_t tok_c;
	count_t      k;
	always_comb begin
		d1_full = r100_s4 - ({3'd0, d10_s4} * 7'd10);
		d1      = d1_full[3:0];
		tok_c   = '0;
		k       = '0;
		if (!rng_s4) begin
			tok_c[0] = WORD_EMPTY;
			k        = 3'd1;
		end else begin
			if (d1000_s4 != 2'd0) begin
				tok_c[k] = {3'd0, d1000_s4};
				k        = k + 3'd1;
				tok_c[k] = WORD_THOUSAND;
				k        = k + 3'd1;
			end
			if (d100_s4 != 4'd0) begin
				tok_c[k] = {1'b0, d100_s4};
				k        = k + 3'd1;
				tok_c[k] = WORD_HUNDRED;
				k        = k + 3'd1;
			end
			if (d10_s4 >= 4'd2) begin
				tok_c[k] = WORD_TWENTY - 5'd2 + {1'b0, d10_s4};
				k        = k + 3'd1;
			end
			if (d10_s4 == 4'd1) begin
				tok_c[k] = WORD_TEN + {1'b0, d1};
				k        = k + 3'd1;
			end else if (d1 != 4'd0) begin
				tok_c[k] = {1'b0, d1};
				k        = k + 3'd1;
			end
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= accept;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			rng_s1   <= (value >= VALUE_MIN) && (value <= VALUE_MAX);
			d1000_s1 <= d1000_c;
			r1000_s1 <= 10'(v12 - sub1000);
		end
		if (rdy_s2) begin
			rng_s2   <= rng_s1;
			d1000_s2 <= d1000_s1;
			r1000_s2 <= r1000_s1;
			d100_s2  <= prod100[SHIFT100 +: 4];
		end
		if (rdy_s3) begin
			rng_s3   <= rng_s2;
			d1000_s3 <= d1000_s2;
			d100_s3  <= d100_s2;
			r100_s3  <= r100_full[6:0];
		end
		if (rdy_s4) begin
			rng_s4   <= rng_s3;
			d1000_s4 <= d1000_s3;
			d100_s4  <= d100_s3;
			r100_s4  <= r100_s3;
			d10_s4   <= prod10[SHIFT10 +: 4];
		end
		if (rdy_s5) begin
			tok_s5 <= tok_c;
			cnt_s5 <= k;
		end
	end

	// Emitter control: act_q is set while tokens of the held list remain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else if (take && v_s5) begin
			act_q    <= (cnt_s5 > 3'd1);
			strobe_q <= 1'b1;
		end else if (act_q) begin
			act_q    <= (idx_q != cnt_q - 3'd1);
			strobe_q <= 1'b1;
		end else begin
			strobe_q <= 1'b0;
		end
	end

	// Emitter payload: the first token goes out as the list loads.
	always_ff @(posedge clk) begin
		if (take && v_s5) begin
			tok_q       <= tok_s5;
			cnt_q       <= cnt_s5;
			idx_q       <= 3'd1;
			word_code_q <= tok_s5[0];
			last_word_q <= (cnt_s5 == 3'd1);
		end else if (act_q) begin
			idx_q       <= idx_q + 3'd1;
			word_code_q <= tok_q[idx_q];
			last_word_q <= (idx_q == cnt_q - 3'd1);
		end
	end

	assign word_code = word_code_q;
	assign last_word = last_word_q;
	assign strobe    = strobe_q;

	// The empty token only comes from an out-of-range value and is its only token.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (word_code == WORD_EMPTY) |-> last_word)
		else $error("empty token not marked last");

	// A token that is not last is followed by another in the next cycle.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_word |=> strobe)
		else $error("gap inside a token list");

	// A held list always has between one and six tokens.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> (cnt_q != 3'd0) && (cnt_q <= 3'd6) && (idx_q < cnt_q))
		else $error("emitter count or index out of range");

	// An accepted value always occupies the first stage.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> v_s1)
		else $error("transfer lost at stage one");

	// A word code above Thousand never leaves the block.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (word_code <= WORD_THOUSAND))
		else $error("word code out of range");

	// A stage-five item waiting on a busy emitter holds its slot.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && act_q |=> v_s5)
		else $error("stalled item dropped");

endmodule
